@@ sv/vsl_pkg.sv @@
// vsl_pkg: shared types, codes and widths of the velocity safety limiter
// used by vsl_arith and velocity_safety_limiter; depends on nothing
package vsl_pkg;

  localparam int VEL_WIDTH   = 16;
  localparam int TIMER_WIDTH = 16;
  localparam int LIM_WIDTH   = 15;
  localparam int PROD_WIDTH  = 2 * VEL_WIDTH;
  localparam int REM_WIDTH   = VEL_WIDTH + 1;
  localparam int CNT_WIDTH   = $clog2(VEL_WIDTH);

  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
  localparam logic [CNT_WIDTH-1:0]   CNT_LAST  = CNT_WIDTH'(VEL_WIDTH - 1);

  // request codes
  localparam logic [1:0] REQ_CMD   = 2'd0;
  localparam logic [1:0] REQ_ATT   = 2'd1;
  localparam logic [1:0] REQ_ESTOP = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_MAX_SPEED   = 2'd0;
  localparam logic [1:0] CFG_MAX_ANGULAR = 2'd1;
  localparam logic [1:0] CFG_TILT_LIMIT  = 2'd2;
  localparam logic [1:0] CFG_DEADMAN     = 2'd3;

  // reason bits
  localparam int RSN_SPEED   = 0;
  localparam int RSN_ANGULAR = 1;
  localparam int RSN_TILT    = 2;
  localparam int RSN_ESTOP   = 3;

  typedef logic signed [VEL_WIDTH-1:0] vel_t;
  typedef logic [VEL_WIDTH-1:0]        mag_t;
  typedef logic [LIM_WIDTH-1:0]        lim_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_S,
    S_CMP,
    S_SQRT,
    S_MUL_X,
    S_DIVI_X,
    S_DIV_X,
    S_MUL_Y,
    S_DIVI_Y,
    S_DIV_Y,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_SQ_X,
    A_SQ_Y,
    A_SQ_S,
    A_CMP,
    A_SQRT,
    A_MUL_X,
    A_MUL_Y,
    A_DIVI,
    A_DIV
  } arith_op_t;

  typedef struct packed {
    arith_op_t op;
  } arith_ctl_t;

  typedef struct packed {
    logic gt;     // planar sum above the speed limit squared
    mag_t quot;   // latest quotient
  } arith_stat_t;

endpackage

@@ sv/vsl_arith.sv @@
// vsl_arith: one multiplier and one shared subtractor with the working
// registers for the squares, the integer square root and the division; uses vsl_pkg
module vsl_arith (
  input  logic                 clk,
  input  vsl_pkg::arith_ctl_t  ctl,
  input  vsl_pkg::mag_t        ax,
  input  vsl_pkg::mag_t        ay,
  input  vsl_pkg::lim_t        ms,
  output vsl_pkg::arith_stat_t stat
);
  import vsl_pkg::*;

  logic [PROD_WIDTH-1:0] prod;
  logic [PROD_WIDTH-1:0] sum;
  logic [REM_WIDTH-1:0]  rem;
  mag_t                  root;
  mag_t                  drem;
  mag_t                  dbuf;
  mag_t                  quot;

  mag_t                  mul_a;
  mag_t                  mul_b;
  logic [PROD_WIDTH-1:0] mul_p;
  mag_t                  ms_ext;
  logic [PROD_WIDTH-1:0] sub_a;
  logic [PROD_WIDTH-1:0] sub_b;
  logic [PROD_WIDTH:0]   diff;
  logic                  ge;
  logic [REM_WIDTH+1:0]  sq_a;
  logic [VEL_WIDTH:0]    dv_a;

  assign ms_ext = VEL_WIDTH'(ms);
  assign sq_a   = {rem, sum[PROD_WIDTH-1 -: 2]};
  assign dv_a   = {drem, dbuf[VEL_WIDTH-1]};

  // operand select of the multiplier
  always_comb begin
    mul_a = ax;
    mul_b = ax;
    case (ctl.op)
      A_SQ_X: begin
        mul_a = ax;
        mul_b = ax;
      end
      A_SQ_Y: begin
        mul_a = ay;
        mul_b = ay;
      end
      A_SQ_S: begin
        mul_a = ms_ext;
        mul_b = ms_ext;
      end
      A_MUL_X: begin
        mul_a = ax;
        mul_b = ms_ext;
      end
      A_MUL_Y: begin
        mul_a = ay;
        mul_b = ms_ext;
      end
      default: begin
        mul_a = ax;
        mul_b = ax;
      end
    endcase
  end

  assign mul_p = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

  // operand select of the shared subtractor
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (ctl.op)
      A_CMP: begin
        sub_a = prod;
        sub_b = sum;
      end
      A_SQRT: begin
        sub_a = PROD_WIDTH'(sq_a);
        sub_b = PROD_WIDTH'({root, 2'b01});
      end
      A_DIV: begin
        sub_a = PROD_WIDTH'(dv_a);
        sub_b = PROD_WIDTH'(root);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = ~diff[PROD_WIDTH];

  always_ff @(posedge clk) begin
    case (ctl.op)
      A_SQ_X: begin
        prod <= mul_p;
        sum  <= '0;
      end
      A_SQ_Y, A_SQ_S: begin
        prod <= mul_p;
        sum  <= sum + prod;
      end
      A_CMP: begin
        rem  <= '0;
        root <= '0;
      end
      A_SQRT: begin
        rem  <= ge ? diff[REM_WIDTH-1:0] : sq_a[REM_WIDTH-1:0];
        root <= {root[VEL_WIDTH-2:0], ge};
        sum  <= {sum[PROD_WIDTH-3:0], 2'b00};
      end
      A_MUL_X, A_MUL_Y: begin
        prod <= mul_p;
      end
      A_DIVI: begin
        drem <= prod[PROD_WIDTH-1:VEL_WIDTH];
        dbuf <= prod[VEL_WIDTH-1:0];
        quot <= '0;
      end
      A_DIV: begin
        drem <= ge ? diff[VEL_WIDTH-1:0] : dv_a[VEL_WIDTH-1:0];
        dbuf <= {dbuf[VEL_WIDTH-2:0], 1'b0};
        quot <= {quot[VEL_WIDTH-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  // sum above limit squared shows as a borrow of prod - sum
  assign stat.gt   = diff[PROD_WIDTH];
  assign stat.quot = quot;

endmodule

@@ sv/velocity_safety_limiter.sv @@
// velocity_safety_limiter: top level with sequencer, safety state and output register
// depends on vsl_pkg and vsl_arith
//
// Gates twist commands on a valid/ready input channel and returns at most one
// limited twist per item on a valid/ready output channel. The block works on
// one item at a time and takes no new item until the current one is finished.
// Attitude items are handled in the idle state alone; estop and tick items
// go on to the finish state to load the output register when they emit a
// result. A command runs the squares and the limit compare through the single
// multiplier and subtractor and then finishes if the planar speed is within
// the limit. When the speed must be limited, the square root follows with one
// result bit per cycle, and then each of the two divisions runs its product,
// load and quotient bits on the same subtractor in turn. A finished
// result waits in the output register until the transfer; a new item is taken
// meanwhile, and only a second result waits for the first to leave.
// Configuration writes are always accepted and are meant for idle periods.
// There is no clearing pass after reset.
module velocity_safety_limiter (
  input  logic                      clk,
  input  logic                      rst,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                req_type,
  input  vsl_pkg::vel_t             lin_x,
  input  vsl_pkg::vel_t             lin_y,
  input  vsl_pkg::vel_t             lin_z,
  input  vsl_pkg::vel_t             ang_x,
  input  vsl_pkg::vel_t             ang_y,
  input  vsl_pkg::vel_t             ang_z,
  input  logic signed [15:0]        roll_angle,
  input  logic signed [15:0]        pitch_angle,
  input  logic                      estop_request,
  // output channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output vsl_pkg::vel_t             safe_lin_x,
  output vsl_pkg::vel_t             safe_lin_y,
  output vsl_pkg::vel_t             safe_lin_z,
  output vsl_pkg::vel_t             safe_ang_x,
  output vsl_pkg::vel_t             safe_ang_y,
  output vsl_pkg::vel_t             safe_ang_z,
  output logic [3:0]                reason_mask,
  output logic                      deadman_trip,
  output logic                      tilt_active,
  output logic                      estop_active,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_data
);
  import vsl_pkg::*;

  // configuration registers
  lim_t                   speed_lim;
  lim_t                   yaw_lim;
  lim_t                   tilt_lim;
  logic [TIMER_WIDTH-1:0] deadman_timeout;

  // safety state
  logic                   estop_flag;
  logic signed [15:0]     roll_store;
  logic signed [15:0]     pitch_store;
  logic [TIMER_WIDTH-1:0] idle_ms;
  logic [3:0]             last_reasons;

  // sequencer
  state_t                 state;
  state_t                 state_next;
  logic [CNT_WIDTH-1:0]   cnt;
  logic                   limit_hit;

  // latched item
  logic [1:0]             typ_r;
  vel_t                   x_r;
  vel_t                   y_r;
  vel_t                   z_r;
  vel_t                   wx_r;
  vel_t                   wy_r;
  vel_t                   wz_r;
  mag_t                   qx;

  arith_ctl_t             actl;
  arith_stat_t            astat;

  logic                   in_xfer;
  logic                   out_load;
  logic [TIMER_WIDTH-1:0] idle_inc;
  logic                   tick_emit;
  mag_t                   ax;
  mag_t                   ay;
  mag_t                   awz;
  mag_t                   aroll;
  mag_t                   apitch;
  logic                   tilted;
  logic                   over_ang;
  vel_t                   lim_x;
  vel_t                   lim_y;
  vel_t                   lim_wz;
  vel_t                   ang_lim;
  logic [3:0]             cmd_reasons;

  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // saturating tick of the idle counter and its deadman check
  assign idle_inc  = (idle_ms == TIMER_MAX) ? idle_ms : idle_ms + 1'b1;
  assign tick_emit = idle_inc > deadman_timeout;

  assign ax     = x_r[VEL_WIDTH-1] ? mag_t'(-x_r) : mag_t'(x_r);
  assign ay     = y_r[VEL_WIDTH-1] ? mag_t'(-y_r) : mag_t'(y_r);
  assign awz    = wz_r[VEL_WIDTH-1] ? mag_t'(-wz_r) : mag_t'(wz_r);
  // magnitude of the most negative angle is taken as 32768
  assign aroll  = roll_store[15] ? mag_t'(-roll_store) : mag_t'(roll_store);
  assign apitch = pitch_store[15] ? mag_t'(-pitch_store) : mag_t'(pitch_store);
  assign tilted = (aroll > mag_t'(tilt_lim)) || (apitch > mag_t'(tilt_lim));

  vsl_arith u_arith (
    .clk  (clk),
    .ctl  (actl),
    .ax   (ax),
    .ay   (ay),
    .ms   (speed_lim),
    .stat (astat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_CMD:   state_next = S_SQ_X;
            REQ_ESTOP: state_next = estop_request ? S_DONE : S_IDLE;
            REQ_TICK:  state_next = tick_emit ? S_DONE : S_IDLE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_SQ_X:   state_next = S_SQ_Y;
      S_SQ_Y:   state_next = S_SQ_S;
      S_SQ_S:   state_next = S_CMP;
      S_CMP:    state_next = astat.gt ? S_SQRT : S_DONE;
      S_SQRT:   state_next = (cnt == CNT_LAST) ? S_MUL_X : S_SQRT;
      S_MUL_X:  state_next = S_DIVI_X;
      S_DIVI_X: state_next = S_DIV_X;
      S_DIV_X:  state_next = (cnt == CNT_LAST) ? S_MUL_Y : S_DIV_X;
      S_MUL_Y:  state_next = S_DIVI_Y;
      S_DIVI_Y: state_next = S_DIV_Y;
      S_DIV_Y:  state_next = (cnt == CNT_LAST) ? S_DONE : S_DIV_Y;
      S_DONE:   state_next = (!out_valid || out_ready) ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    actl.op  = A_NONE;
    case (state)
      S_IDLE:   in_ready = 1'b1;
      S_SQ_X:   actl.op = A_SQ_X;
      S_SQ_Y:   actl.op = A_SQ_Y;
      S_SQ_S:   actl.op = A_SQ_S;
      S_CMP:    actl.op = A_CMP;
      S_SQRT:   actl.op = A_SQRT;
      S_MUL_X:  actl.op = A_MUL_X;
      S_DIVI_X: actl.op = A_DIVI;
      S_DIV_X:  actl.op = A_DIV;
      S_MUL_Y:  actl.op = A_MUL_Y;
      S_DIVI_Y: actl.op = A_DIVI;
      S_DIV_Y:  actl.op = A_DIV;
      S_DONE:   out_load = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
        actl.op  = A_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      // loop counter restarts on every state change
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
    end
  end

  // limit flag and the first quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_hit <= 1'b0;
    end else if (state == S_CMP) begin
      limit_hit <= astat.gt;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL_Y) begin
      qx <= astat.quot;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      typ_r <= req_type;
      x_r   <= lin_x;
      y_r   <= lin_y;
      z_r   <= lin_z;
      wx_r  <= ang_x;
      wy_r  <= ang_y;
      wz_r  <= ang_z;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_lim       <= LIM_WIDTH'(4096);
      yaw_lim         <= LIM_WIDTH'(4096);
      tilt_lim        <= LIM_WIDTH'(3000);
      deadman_timeout <= TIMER_WIDTH'(300);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_SPEED:   speed_lim       <= cfg_data[LIM_WIDTH-1:0];
        CFG_MAX_ANGULAR: yaw_lim         <= cfg_data[LIM_WIDTH-1:0];
        CFG_TILT_LIMIT:  tilt_lim        <= cfg_data[LIM_WIDTH-1:0];
        CFG_DEADMAN:     deadman_timeout <= TIMER_WIDTH'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // safety state: updated at the input transfer, reasons at the result
  always_ff @(posedge clk) begin
    if (rst) begin
      estop_flag   <= 1'b0;
      roll_store   <= '0;
      pitch_store  <= '0;
      idle_ms      <= TIMER_MAX;
      last_reasons <= '0;
    end else begin
      if (in_xfer) begin
        case (req_type)
          REQ_CMD:   idle_ms <= '0;
          REQ_ATT: begin
            roll_store  <= roll_angle;
            pitch_store <= pitch_angle;
          end
          REQ_ESTOP: estop_flag <= estop_request;
          REQ_TICK:  idle_ms <= idle_inc;
          default: begin
          end
        endcase
      end
      if (out_load && typ_r == REQ_CMD) begin
        last_reasons <= cmd_reasons;
      end
    end
  end

  // final limiting of a command
  assign ang_lim  = vel_t'(yaw_lim);
  assign over_ang = awz > mag_t'(yaw_lim);

  always_comb begin
    lim_x  = x_r;
    lim_y  = y_r;
    lim_wz = wz_r;
    if (limit_hit) begin
      lim_x = x_r[VEL_WIDTH-1] ? -vel_t'(qx) : vel_t'(qx);
      lim_y = y_r[VEL_WIDTH-1] ? -vel_t'(astat.quot) : vel_t'(astat.quot);
    end
    if (over_ang) begin
      lim_wz = wz_r[VEL_WIDTH-1] ? -ang_lim : ang_lim;
    end
    if (tilted) begin
      lim_x  = '0;
      lim_y  = '0;
      lim_wz = '0;
    end
    cmd_reasons              = '0;
    cmd_reasons[RSN_SPEED]   = limit_hit;
    cmd_reasons[RSN_ANGULAR] = over_ang;
    cmd_reasons[RSN_TILT]    = tilted;
    cmd_reasons[RSN_ESTOP]   = estop_flag;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      deadman_trip   <= idle_ms > deadman_timeout;
      tilt_active    <= tilted;
      estop_active   <= estop_flag;
      if (typ_r == REQ_CMD && !estop_flag) begin
        safe_lin_x  <= lim_x;
        safe_lin_y  <= lim_y;
        safe_lin_z  <= z_r;
        safe_ang_x  <= wx_r;
        safe_ang_y  <= wy_r;
        safe_ang_z  <= lim_wz;
        reason_mask <= cmd_reasons;
      end else begin
        // estop, deadman tick, or command under estop: zero twist
        safe_lin_x  <= '0;
        safe_lin_y  <= '0;
        safe_lin_z  <= '0;
        safe_ang_x  <= '0;
        safe_ang_y  <= '0;
        safe_ang_z  <= '0;
        reason_mask <= (typ_r == REQ_CMD) ? cmd_reasons : last_reasons;
      end
    end
  end

  // a result only appears after the finish step of the sequencer
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result without finished item");

  // an estop reason with the estop flag active always comes with a zero twist
  a_estop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && reason_mask[RSN_ESTOP] && estop_active |->
      safe_lin_x == '0 && safe_lin_y == '0 && safe_lin_z == '0 &&
      safe_ang_x == '0 && safe_ang_y == '0 && safe_ang_z == '0)
    else $error("motion under emergency stop");

  // the divisions only run after the limit compare found an overspeed
  a_div_needs_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV_X || state == S_DIV_Y |-> limit_hit)
    else $error("division without speed limiting");

endmodule
